>>> sv/gat_pkg.sv
// ----------------------------------------------------------------------------
// gat_pkg
// Types and constants for the Gaussian adaptive threshold block.
// ----------------------------------------------------------------------------
package gat_pkg;

	localparam int RADIUS      = 3;
	localparam int MAX_WIDTH   = 1024;
	localparam int WEIGHT_BITS = 16;

	localparam int KSIZE   = 2 * RADIUS + 1;
	localparam int NSLOTS  = 2 * RADIUS;
	localparam int PIX_W   = 24;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 12;
	localparam int SLOT_W  = 3;
	localparam int FW_W    = 11;
	localparam int FH_W    = 12;
	localparam int OFF_W   = 9;
	localparam int MEAN_W  = 25;
	localparam int CFG_W   = 12;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_OFFSET_C     = 2'd2
	} cfg_index_t;

	// normalized Gaussian weights, Q0.16, sigma = RADIUS/3
	localparam logic [WEIGHT_BITS-1:0] WTAB [KSIZE][KSIZE] = '{
		'{16'd1,   16'd16,   16'd70,   16'd116,   16'd70,   16'd16,   16'd1},
		'{16'd16,  16'd191,  16'd857,  16'd1412,  16'd857,  16'd191,  16'd16},
		'{16'd70,  16'd857,  16'd3839, 16'd6330,  16'd3839, 16'd857,  16'd70},
		'{16'd116, 16'd1412, 16'd6330, 16'd10436, 16'd6330, 16'd1412, 16'd116},
		'{16'd70,  16'd857,  16'd3839, 16'd6330,  16'd3839, 16'd857,  16'd70},
		'{16'd16,  16'd191,  16'd857,  16'd1412,  16'd857,  16'd191,  16'd16},
		'{16'd1,   16'd16,   16'd70,   16'd116,   16'd70,   16'd16,   16'd1}
	};

	typedef logic [NSLOTS-1:0][PIX_W-1:0] lanes_t;

	typedef struct packed {
		logic       start_of_frame;
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pix_in_t;

	typedef struct packed {
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic [7:0]       out_red;
		logic [7:0]       out_green;
		logic [7:0]       out_blue;
	} pix_out_t;

endpackage

>>> sv/gat_ram.sv
// ----------------------------------------------------------------------------
// gat_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/gaussian_adaptive_threshold_rgb.sv
// ----------------------------------------------------------------------------
// gaussian_adaptive_threshold_rgb
// Per-channel inverse binary threshold against a 7x7 Gaussian-weighted mean.
// ----------------------------------------------------------------------------
// Accepts one RGB pixel per clock in raster order unless stalled and returns
// one result per interior pixel via the window, row sum and total registers.
// The six line stores share one 1024 x 144-bit RAM, one column per word, read
// when a pixel is taken and written back the next cycle; a same-column
// back-to-back access is forwarded. Results wait in an 8-entry queue; the
// input stalls only when that queue plus the in-flight stages could overflow.
module gaussian_adaptive_threshold_rgb
	import gat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  pix_in_t          pix,
	output logic             res_valid,
	input  logic             res_stall,
	output pix_out_t         res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [FW_W-1:0]         frame_width_q;
	logic [FH_W-1:0]         frame_height_q;
	logic signed [OFF_W-1:0] offset_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(640);
			frame_height_q <= FH_W'(480);
			offset_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
				CFG_OFFSET_C:     offset_q       <= signed'(cfg_data[OFF_W-1:0]);
				default: ;
			endcase
		end
	end

	// position counters
	logic [COL_W-1:0]  col_q, col_cur;
	logic [ROW_W-1:0]  row_q, row_cur;
	logic [SLOT_W-1:0] slot_q, slot_cur;
	logic [FW_W-1:0]   eff_w;
	logic [FH_W-1:0]   eff_h;
	logic              accept, col_wrap, row_wrap, emit_cur;

	assign accept   = pix_valid && !pix_stall;
	assign col_cur  = pix.start_of_frame ? '0 : col_q;
	assign row_cur  = pix.start_of_frame ? '0 : row_q;
	assign slot_cur = pix.start_of_frame ? '0 : slot_q;
	assign eff_w    = (frame_width_q > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) :
		(frame_width_q == '0) ? FW_W'(1) : frame_width_q;
	assign eff_h    = (frame_height_q == '0) ? FH_W'(1) : frame_height_q;
	assign col_wrap = ({1'b0, col_cur} + FW_W'(1)) >= eff_w;
	assign row_wrap = ({1'b0, row_cur} + (FH_W+1)'(1)) >= {1'b0, eff_h};
	assign emit_cur = (row_cur >= ROW_W'(NSLOTS)) && (col_cur >= COL_W'(NSLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_cur + ROW_W'(1);
					slot_q <= (slot_cur == SLOT_W'(NSLOTS - 1)) ? '0 :
						slot_cur + SLOT_W'(1);
				end
			end else begin
				col_q  <= col_cur + COL_W'(1);
				row_q  <= row_cur;
				slot_q <= slot_cur;
			end
		end
	end

	// stage 1: line store read-modify-write and window shift
	logic              v_s1, emit_s1, fwd_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [ROW_W-1:0]  orow_s1;
	logic [COL_W-1:0]  ocol_s1;
	lanes_t            ram_rdata, rd_word, wr_word, wr_word_q;
	logic [PIX_W-1:0]  new_col [NSLOTS];

	gat_ram #(
		.WIDTH(NSLOTS * PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(col_s1),
		.wdata(wr_word),
		.re   (accept),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1   <= accept;
			fwd_s1 <= accept && v_s1 && (col_cur == col_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= {pix.pixel_red, pix.pixel_green, pix.pixel_blue};
			col_s1  <= col_cur;
			slot_s1 <= slot_cur;
			emit_s1 <= emit_cur;
			orow_s1 <= row_cur - ROW_W'(RADIUS);
			ocol_s1 <= col_cur - COL_W'(RADIUS);
		end
		if (v_s1) begin
			wr_word_q <= wr_word;
		end
	end

	always_comb begin
		logic [SLOT_W:0] idx;
		rd_word = fwd_s1 ? wr_word_q : ram_rdata;
		wr_word = rd_word;
		wr_word[slot_s1] = pix_s1;
		for (int i = 0; i < NSLOTS; i++) begin
			idx = {1'b0, slot_s1} + (SLOT_W+1)'(i);
			if (idx >= (SLOT_W+1)'(NSLOTS)) begin
				idx = idx - (SLOT_W+1)'(NSLOTS);
			end
			new_col[i] = rd_word[idx[SLOT_W-1:0]];
		end
	end

	logic [PIX_W-1:0] win_q [KSIZE][KSIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KSIZE; i++) begin
				for (int j = 0; j < KSIZE; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (v_s1) begin
			for (int i = 0; i < KSIZE; i++) begin
				for (int j = 0; j < KSIZE - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
			end
			for (int i = 0; i < NSLOTS; i++) begin
				win_q[i][KSIZE-1] <= new_col[i];
			end
			win_q[NSLOTS][KSIZE-1] <= pix_s1;
		end
	end

	// stage 2: weighted row sums, then the totals and the threshold compare
	logic              v_s2, v_s3, v_s4;
	logic [ROW_W-1:0]  orow_s2, orow_s3, orow_s4;
	logic [COL_W-1:0]  ocol_s2, ocol_s3, ocol_s4;
	logic [MEAN_W-1:0] rsum [3][KSIZE];
	logic [MEAN_W-1:0] rsum_s3 [3][KSIZE];
	logic [PIX_W-1:0]  center_s3, center_s4;
	logic [MEAN_W-1:0] total [3];
	logic [MEAN_W-1:0] total_s4 [3];
	logic [2:0]        hit;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < KSIZE; i++) begin
				rsum[c][i] = '0;
				for (int j = 0; j < KSIZE; j++) begin
					rsum[c][i] = rsum[c][i] + MEAN_W'(WTAB[i][j]) *
						MEAN_W'(win_q[i][j][8*c +: 8]);
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			total[c] = '0;
			for (int i = 0; i < KSIZE; i++) begin
				total[c] = total[c] + rsum_s3[c][i];
			end
		end
	end

	always_comb begin
		logic signed [9:0]  sum10;
		logic signed [26:0] lhs;
		logic signed [26:0] mean;
		for (int c = 0; c < 3; c++) begin
			sum10 = signed'({2'b00, center_s4[8*c +: 8]}) + 10'(offset_q);
			lhs   = signed'({sum10[9], sum10, 16'b0});
			mean  = signed'({2'b00, total_s4[c]});
			hit[c] = lhs < mean;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		orow_s2   <= orow_s1;
		ocol_s2   <= ocol_s1;
		orow_s3   <= orow_s2;
		ocol_s3   <= ocol_s2;
		center_s3 <= win_q[RADIUS][RADIUS];
		rsum_s3   <= rsum;
		orow_s4   <= orow_s3;
		ocol_s4   <= ocol_s3;
		center_s4 <= center_s3;
		total_s4  <= total;
	end

	// result queue
	pix_out_t          fifo_q [FIFO_DEPTH];
	pix_out_t          push_data;
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_AW:0]   fcnt_q;
	logic [FIFO_AW+1:0] occupancy;
	logic               pop;

	assign push_data.out_row   = orow_s4;
	assign push_data.out_col   = ocol_s4;
	assign push_data.out_red   = {8{hit[2]}};
	assign push_data.out_green = {8{hit[1]}};
	assign push_data.out_blue  = {8{hit[0]}};

	assign res_valid = (fcnt_q != '0);
	assign res       = fifo_q[rptr_q];
	assign pop       = res_valid && !res_stall;
	assign occupancy = (FIFO_AW+2)'(fcnt_q) + (FIFO_AW+2)'(v_s1) +
		(FIFO_AW+2)'(v_s2) + (FIFO_AW+2)'(v_s3) + (FIFO_AW+2)'(v_s4);
	assign pix_stall = occupancy >= (FIFO_AW+2)'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fcnt_q <= '0;
		end else begin
			if (v_s4) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			fcnt_q <= fcnt_q + (FIFO_AW+1)'(v_s4) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) begin
			fifo_q[wptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (fcnt_q != (FIFO_AW+1)'(FIFO_DEPTH)))
		else $error("result queue overflow");

	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forward without stage 1 request");

	a_s2_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("stage 2 without stage 1");

	a_fcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("queue count out of range");

endmodule

>>> sim/gat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gat_checker
// Watches the pixel, result and register channels of the threshold block.
// ----------------------------------------------------------------------------
// Keeps its own copy of the line stores, the 7x7 window, the raster counters
// and the registers. It works out the thresholded center pixel for each pixel
// taken that completes a window and compares each result with it, in order.
// ----------------------------------------------------------------------------
module gat_checker
	import gat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	input  logic             pix_stall,
	input  pix_in_t          pix,
	input  logic             res_valid,
	input  logic             res_stall,
	input  pix_out_t         res,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               pending,
	output int               mismatches
);

	longint            gauss_w [KSIZE][KSIZE];
	logic [PIX_W-1:0]  lines [NSLOTS][MAX_WIDTH];
	logic [PIX_W-1:0]  win [KSIZE][KSIZE];
	int unsigned       col_cnt, row_cnt;
	logic [FW_W-1:0]   width_reg;
	logic [FH_W-1:0]   height_reg;
	logic signed [OFF_W-1:0] offset_reg;
	pix_out_t          expected_px [$];
	pix_out_t          want;

	// Gaussian taps: exp(-x) by Taylor series of exp(x) in Q32, then Q18
	initial begin
		longint unsigned g [RADIUS+1];
		longint unsigned term, total, num, dsq;
		for (int k = 0; k <= RADIUS; k++) begin
			num = 9 * k * k;
			term = 64'd1 << 32;
			total = term;
			for (int n = 1; n <= 64 && term != 0; n++) begin
				term = term * num / (2 * RADIUS * RADIUS * n);
				total += term;
			end
			g[k] = ((64'd1 << 50) + total / 2) / total;
		end
		total = g[0];
		for (int k = 1; k <= RADIUS; k++)
			total += 2 * g[k];
		dsq = total * total;
		for (int i = 0; i < KSIZE; i++)
			for (int j = 0; j < KSIZE; j++)
				gauss_w[i][j] = longint'((((g[(i < RADIUS) ? RADIUS - i : i - RADIUS] *
					g[(j < RADIUS) ? RADIUS - j : j - RADIUS]) << WEIGHT_BITS) +
					dsq / 2) / dsq);
	end

	function automatic logic [7:0] below_mean(int sh);
		longint mean;
		longint lhs;
		mean = 0;
		for (int i = 0; i < KSIZE; i++)
			for (int j = 0; j < KSIZE; j++)
				mean += gauss_w[i][j] * longint'(win[i][j][sh+:8]);
		lhs = (longint'(win[RADIUS][RADIUS][sh+:8]) + longint'(offset_reg)) *
			(longint'(1) << WEIGHT_BITS);
		return (lhs < mean) ? 8'hFF : 8'h00;
	endfunction

	task automatic take_pixel(input pix_in_t p);
		int unsigned eff_w, eff_h, c;
		pix_out_t r;
		eff_w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
		eff_h = height_reg;
		if (eff_w == 0) eff_w = 1;
		if (eff_h == 0) eff_h = 1;
		if (p.start_of_frame) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = col_cnt % MAX_WIDTH;
		for (int i = 0; i < KSIZE; i++)
			for (int j = 0; j < KSIZE - 1; j++)
				win[i][j] = win[i][j+1];
		for (int i = 0; i < NSLOTS; i++)
			win[i][KSIZE-1] = lines[(row_cnt + i) % NSLOTS][c];
		win[NSLOTS][KSIZE-1] = {p.pixel_red, p.pixel_green, p.pixel_blue};
		lines[row_cnt % NSLOTS][c] = {p.pixel_red, p.pixel_green, p.pixel_blue};
		if (row_cnt >= NSLOTS && col_cnt >= NSLOTS) begin
			r.out_row   = ROW_W'(row_cnt - RADIUS);
			r.out_col   = COL_W'(col_cnt - RADIUS);
			r.out_red   = below_mean(16);
			r.out_green = below_mean(8);
			r.out_blue  = below_mean(0);
			expected_px.push_back(r);
		end
		if (col_cnt + 1 >= eff_w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= eff_h) ? 0 : row_cnt + 1;
		end else begin
			col_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  <= 640;
			height_reg <= 480;
			offset_reg <= '0;
			col_cnt    = 0;
			row_cnt    = 0;
			for (int i = 0; i < NSLOTS; i++)
				for (int j = 0; j < MAX_WIDTH; j++)
					lines[i][j] = '0;
			for (int i = 0; i < KSIZE; i++)
				for (int j = 0; j < KSIZE; j++)
					win[i][j] = '0;
			expected_px.delete();
			pending    <= 0;
			mismatches <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_px.size() == 0) begin
					if (mismatches < 10)
						$display("%t unexpected result row %0d col %0d rgb %h %h %h",
							$realtime, res.out_row, res.out_col,
							res.out_red, res.out_green, res.out_blue);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_px.pop_front();
					if (res !== want) begin
						if (mismatches < 10)
							$display("%t result mismatch: exp row %0d col %0d rgb %h %h %h, got row %0d col %0d rgb %h %h %h",
								$realtime, want.out_row, want.out_col, want.out_red,
								want.out_green, want.out_blue, res.out_row, res.out_col,
								res.out_red, res.out_green, res.out_blue);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
					CFG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
					CFG_OFFSET_C:     offset_reg <= cfg_data[OFF_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall)
				take_pixel(pix);
			pending <= expected_px.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Gaussian adaptive threshold block.
// ----------------------------------------------------------------------------
// Runs directed frames (pixel extremes, offset extremes, width and height
// outside their range, wrap past the frame end, width cut mid-frame) and
// then random small frames with broken sequences mixed in.
// Both sides idle at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import gat_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam int KIND_NOISE = 0;
	localparam int KIND_SMOOTH = 1;
	localparam int KIND_EXTREME = 2;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             pix_valid = 1'b0;
	logic             pix_stall;
	pix_in_t          pix = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	pix_out_t         res;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = CFG_FRAME_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	int               pending, mismatches;
	bit               calm = 1'b0;
	int               random_sent;

	always #1 clk = ~clk;

	gaussian_adaptive_threshold_rgb dut (.*);

	gat_checker chk (.*);

	always @(posedge clk)
		res_stall <= !calm && ($urandom_range(99) < 17);

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic send_pixel(input pix_in_t p);
		if (!calm && $urandom_range(99) < 20) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		do @(posedge clk); while (pix_stall);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		pix_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_frame(input int w, input int h, input int off);
		drain();
		write_reg(CFG_FRAME_WIDTH, {1'($urandom), FW_W'(w)});
		write_reg(CFG_FRAME_HEIGHT, FH_W'(h));
		write_reg(CFG_OFFSET_C, {3'($urandom), OFF_W'(off)});
	endtask

	function automatic logic [7:0] chan(input int kind, input int base);
		int v;
		case (kind)
			KIND_SMOOTH: begin
				v = base + int'($urandom_range(0, 40)) - 20;
				return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
			end
			KIND_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// break_pm: per-mille chance of a stray start of frame
	task automatic run_pixels(input int n, input bit sof_first, input int kind,
			input int break_pm);
		int base;
		pix_in_t p;
		base = $urandom_range(20, 235);
		for (int k = 0; k < n; k++) begin
			p.start_of_frame = (k == 0 && sof_first) || ($urandom_range(999) < break_pm);
			p.pixel_red   = chan(kind, base);
			p.pixel_green = chan(kind, base);
			p.pixel_blue  = chan(kind, base);
			send_pixel(p);
			if ($urandom_range(63) == 0) base = $urandom_range(20, 235);
		end
	endtask

	initial begin
		int w, h, off, n, frames;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame(7, 7, 0);
		run_pixels(49, 1, KIND_EXTREME, 0);
		set_frame(7, 7, -255);
		run_pixels(49, 1, KIND_EXTREME, 0);
		set_frame(7, 7, 255);
		run_pixels(49, 1, KIND_EXTREME, 0);
		set_frame(10, 9, 0);
		run_pixels(90, 1, KIND_SMOOTH, 0);
		// wrap past the end of the frame
		set_frame(9, 8, -3);
		run_pixels(9 * 8 * 2 + 20, 1, KIND_SMOOTH, 0);
		// width cut mid-frame with the column already past the new width
		set_frame(12, 10, 4);
		run_pixels(12 * 8 + 10, 1, KIND_SMOOTH, 0);
		drain();
		write_reg(CFG_FRAME_WIDTH, FW_W'(8));
		run_pixels(60, 0, KIND_SMOOTH, 0);
		drain();
		write_reg(CFG_SPARE, CFG_W'($urandom));
		set_frame(0, 9, 0);
		run_pixels(30, 1, KIND_NOISE, 0);
		set_frame(8, 0, 0);
		run_pixels(30, 1, KIND_NOISE, 0);
		set_frame(7, 4095, 2);
		run_pixels(100, 1, KIND_SMOOTH, 0);

		random_sent = 0;
		frames = 0;
		while (random_sent < 550) begin
			w = ($urandom_range(7) == 0) ? $urandom_range(21, 48) : $urandom_range(7, 20);
			h = $urandom_range(7, 12);
			off = ($urandom_range(3) == 0) ? int'($urandom_range(0, 510)) - 255
				: int'($urandom_range(0, 20)) - 10;
			set_frame(w, h, off);
			calm = (frames == 1 || frames == 2);
			n = ($urandom_range(4) == 0) ? $urandom_range(10, w * h) : w * h;
			if ($urandom_range(5) == 0) n = n * 2;
			run_pixels(n, 1, ($urandom_range(3) == 0) ? KIND_NOISE : KIND_SMOOTH,
				($urandom_range(9) == 0) ? 8 : 0);
			random_sent += n;
			frames++;
		end
		calm = 1'b0;

		pix_valid <= 1'b0;
		for (int guard = 0; guard < 5000 && pending != 0; guard++) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
